/* design/tcw_pkg.sv */
package tcw_pkg;

  // Cell store and screen geometry
  localparam int MEM_WORDS    = 4096;
  localparam int ADDR_W       = $clog2(MEM_WORDS);
  localparam int LIM_W        = ADDR_W + 1;
  localparam int LINE_CELLS   = 80;
  localparam int COL_W        = $clog2(LINE_CELLS);
  localparam int SCREEN_CELLS = 2000;
  localparam int TAB_STOP     = 4;
  localparam int TAB_W        = $clog2(TAB_STOP);
  localparam int TAB_GUARD    = TAB_STOP + 1;
  localparam int CHAR_W       = 8;
  localparam int CELL_W       = 2 * CHAR_W;
  localparam int CMD_W        = 2;
  localparam int QUEUE_DEPTH  = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = LIM_W;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH = 1'd1;
  localparam logic [LIM_W-1:0]     REGION_RESET = 13'd4080;

  // Commands
  localparam logic [CMD_W-1:0] CMD_PUT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DOWN = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd3;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // Operations handed from front to back
  typedef logic [2:0] op_t;
  localparam op_t OP_NONE = 3'd0;
  localparam op_t OP_CHR  = 3'd1;
  localparam op_t OP_NL   = 3'd2;
  localparam op_t OP_BS   = 3'd3;
  localparam op_t OP_TAB  = 3'd4;
  localparam op_t OP_UP   = 3'd5;
  localparam op_t OP_DOWN = 3'd6;
  localparam op_t OP_READ = 3'd7;

  typedef struct packed {
    op_t                op;
    logic [CHAR_W-1:0]  ch;
    logic [CHAR_W-1:0]  color;
    logic [ADDR_W-1:0]  addr;
  } tcw_item_t;

endpackage

/* design/tcw_in_if.sv */
interface tcw_in_if
  import tcw_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [CHAR_W-1:0] ch;
  logic [CHAR_W-1:0] color;
  logic [ADDR_W-1:0] addr;

  modport source (output valid, output cmd, output ch, output color, output addr,
                  input ready);
  modport sink   (input valid, input cmd, input ch, input color, input addr,
                  output ready);
endinterface

/* design/tcw_out_if.sv */
interface tcw_out_if
  import tcw_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] cursor_pos;
  logic [ADDR_W-1:0] view_start;
  logic [CHAR_W-1:0] cell_char;
  logic [CHAR_W-1:0] cell_attr;

  modport source (output valid, output cursor_pos, output view_start,
                  output cell_char, output cell_attr, input ready);
  modport sink   (input valid, input cursor_pos, input view_start,
                  input cell_char, input cell_attr, output ready);
endinterface

/* design/tcw_front.sv */
module tcw_front
  import tcw_pkg::*;
(
  tcw_in_if.sink    in_bus,
  input  logic      search_mode,
  input  logic      clear_busy,
  input  logic      q_full,
  output logic      push,
  output tcw_item_t push_item
);

  assign in_bus.ready = !q_full && !clear_busy;
  assign push         = in_bus.valid && in_bus.ready;

  always_comb begin
    push_item.ch    = in_bus.ch;
    push_item.color = in_bus.color;
    push_item.addr  = in_bus.addr;
    unique case (in_bus.cmd)
      CMD_PUT: begin
        unique case (in_bus.ch)
          CH_NL:   push_item.op = OP_NL;
          // backspace in search mode only runs the view follow
          CH_BS:   push_item.op = search_mode ? OP_NONE : OP_BS;
          CH_TAB:  push_item.op = OP_TAB;
          default: push_item.op = OP_CHR;
        endcase
      end
      CMD_UP:   push_item.op = OP_UP;
      CMD_DOWN: push_item.op = OP_DOWN;
      CMD_READ: push_item.op = OP_READ;
      default:  push_item.op = OP_NONE;
    endcase
  end

endmodule

/* design/tcw_queue.sv */
module tcw_queue
  import tcw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  tcw_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output tcw_item_t pop_item
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  tcw_item_t        slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_item  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* design/tcw_back.sv */
module tcw_back
  import tcw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [LIM_W-1:0] region_size,
  input  logic             q_valid,
  input  tcw_item_t        q_item,
  output logic             pop,
  output logic             clear_busy,
  tcw_out_if.source        out_bus
);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_FILL_NL  = 4'd2;
  localparam logic [3:0] S_FILL_TAB = 4'd3;
  localparam logic [3:0] S_BS_CHK   = 4'd4;
  localparam logic [3:0] S_BS_RD    = 4'd5;
  localparam logic [3:0] S_SCROLL   = 4'd6;
  localparam logic [3:0] S_DONE     = 4'd7;

  logic [3:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [ADDR_W-1:0] cursor_r, cursor_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ADDR_W-1:0] start_r, start_nxt;
  logic              first_r, first_nxt;
  logic              rd_sel_r, rd_sel_nxt;
  logic [CHAR_W-1:0] color_r;
  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_cursor_r, out_start_r;
  logic [CHAR_W-1:0] out_char_r, out_attr_r;

  logic [CELL_W-1:0] mem [MEM_WORDS];
  logic [CELL_W-1:0] rdata_r;
  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [CELL_W-1:0] wdata;

  logic [LIM_W-1:0]  lim;
  logic [LIM_W-1:0]  cur_ext, screen_end;
  logic              view_ok, past_view;
  logic [ADDR_W-1:0] cursor_inc, cursor_dec;
  logic [COL_W-1:0]  col_inc, col_dec;

  assign lim        = (region_size > LIM_W'(MEM_WORDS)) ? LIM_W'(MEM_WORDS) : region_size;
  assign cur_ext    = LIM_W'(cursor_r);
  assign screen_end = LIM_W'(start_r) + LIM_W'(SCREEN_CELLS);
  assign view_ok    = screen_end < lim;
  assign past_view  = cur_ext >= screen_end;
  assign cursor_inc = cursor_r + 1'b1;
  assign cursor_dec = cursor_r - 1'b1;
  assign col_inc    = (col_r == COL_W'(LINE_CELLS - 1)) ? '0 : col_r + 1'b1;
  assign col_dec    = (col_r == '0) ? COL_W'(LINE_CELLS - 1) : col_r - 1'b1;

  assign clear_busy = (state_r == S_CLEAR);
  assign pop        = (state_r == S_IDLE) && q_valid && !out_valid_r;

  assign out_bus.valid      = out_valid_r;
  assign out_bus.cursor_pos = out_cursor_r;
  assign out_bus.view_start = out_start_r;
  assign out_bus.cell_char  = out_char_r;
  assign out_bus.cell_attr  = out_attr_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cursor_nxt    = cursor_r;
    col_nxt       = col_r;
    start_nxt     = start_r;
    first_nxt     = first_r;
    rd_sel_nxt    = rd_sel_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    we            = 1'b0;
    waddr         = cursor_r;
    wdata         = {color_r, CH_NUL};
    raddr         = cursor_dec;

    unique case (state_r)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r;
        wdata = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (pop) begin
          rd_sel_nxt = (q_item.op == OP_READ);
          first_nxt  = 1'b1;
          unique case (q_item.op)
            OP_CHR: begin
              if (cur_ext + LIM_W'(1) < lim) begin
                we         = 1'b1;
                wdata      = {q_item.color, q_item.ch};
                cursor_nxt = cursor_inc;
                col_nxt    = col_inc;
              end
              state_nxt = S_SCROLL;
            end
            OP_NL: begin
              state_nxt = (cur_ext + LIM_W'(LINE_CELLS) < lim) ? S_FILL_NL : S_SCROLL;
            end
            OP_TAB: begin
              state_nxt = (cur_ext + LIM_W'(TAB_GUARD) < lim) ? S_FILL_TAB : S_SCROLL;
            end
            OP_BS: begin
              state_nxt = (cursor_r == '0) ? S_SCROLL : S_BS_CHK;
            end
            OP_UP: begin
              if (start_r >= ADDR_W'(LINE_CELLS)) begin
                start_nxt = start_r - ADDR_W'(LINE_CELLS);
              end else begin
                start_nxt = '0;
              end
              state_nxt = S_DONE;
            end
            OP_DOWN: begin
              if (view_ok) begin
                start_nxt = start_r + ADDR_W'(LINE_CELLS);
              end
              state_nxt = S_DONE;
            end
            OP_READ: begin
              raddr     = q_item.addr;
              state_nxt = S_DONE;
            end
            default: state_nxt = S_SCROLL;
          endcase
        end
      end
      S_FILL_NL: begin
        we         = 1'b1;
        cursor_nxt = cursor_inc;
        col_nxt    = col_inc;
        if (col_r == COL_W'(LINE_CELLS - 1)) begin
          state_nxt = S_SCROLL;
        end
      end
      S_FILL_TAB: begin
        we         = 1'b1;
        cursor_nxt = cursor_inc;
        col_nxt    = col_inc;
        if (cursor_r[TAB_W-1:0] == '1) begin
          state_nxt = S_SCROLL;
        end
      end
      S_BS_CHK: begin
        // rdata_r holds the cell left of the cursor
        first_nxt = 1'b0;
        waddr     = cursor_dec;
        wdata     = {color_r, CH_SPACE};
        if (rdata_r[CHAR_W-1:0] != CH_NUL) begin
          if (first_r) begin
            we         = 1'b1;
            cursor_nxt = cursor_dec;
            col_nxt    = col_dec;
          end
          state_nxt = S_SCROLL;
        end else begin
          we         = 1'b1;
          cursor_nxt = cursor_dec;
          col_nxt    = col_dec;
          // stop walking once the erased cell was the line start
          state_nxt  = (col_r != COL_W'(1)) ? S_BS_RD : S_SCROLL;
        end
      end
      S_BS_RD: begin
        state_nxt = (cursor_r == '0) ? S_SCROLL : S_BS_CHK;
      end
      S_SCROLL: begin
        if (past_view && view_ok) begin
          start_nxt = start_r + ADDR_W'(LINE_CELLS);
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cursor_r    <= '0;
      col_r       <= '0;
      start_r     <= '0;
      first_r     <= 1'b0;
      rd_sel_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cursor_r    <= cursor_nxt;
      col_r       <= col_nxt;
      start_r     <= start_nxt;
      first_r     <= first_nxt;
      rd_sel_r    <= rd_sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      color_r <= q_item.color;
    end
    if (state_r == S_DONE) begin
      out_cursor_r <= cursor_r;
      out_start_r  <= start_r;
      out_char_r   <= rd_sel_r ? rdata_r[CHAR_W-1:0] : CH_NUL;
      out_attr_r   <= rd_sel_r ? rdata_r[CELL_W-1:CHAR_W] : CH_NUL;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

`ifndef NO_ASSERTIONS
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r < COL_W'(LINE_CELLS))
    else $error("column counter out of range");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside done state");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !pop)
    else $error("item taken during clearing pass");

  a_fill_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL_NL || state_r == S_FILL_TAB) |=>
      cursor_r == ADDR_W'($past(cursor_r) + 1'b1))
    else $error("fill did not advance cursor");
`endif

endmodule

/* design/text_console_writer_core.sv */
// Channel   Dir  Payload                                          Handshake
// in_bus    in   cmd, ch, color, addr                             valid/ready
// out_bus   out  cursor_pos, view_start, cell_char, cell_attr     valid/ready
// cfg_*     in   cfg_index, cfg_wdata (region_size, search_mode)  cfg_we, no wait
//
// The work per item with out_bus ready depends on its kind: a newline fills every cell
// to the end of the line, a tab fills up to the next tab stop, a backspace steps back over
// empty cells, and each automatic view step adds a scroll state. The cell store (one write
// port, one read port) and the back-end sequencer set this.
// Reset: synchronous; then a clearing pass zeroes all 4096 words of the cell store
// while in_bus.ready stays low (configuration writes are still taken).
// Stalls: a 2-entry queue lets input beats land while the back end works or while
// a result waits on out_bus.
module text_console_writer_core
  import tcw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  tcw_in_if.sink                in_bus,
  tcw_out_if.source             out_bus,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [LIM_W-1:0] region_r;
  logic             search_r;
  logic             clear_busy;
  logic             q_full, q_not_empty, push, pop;
  tcw_item_t        push_item, pop_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_r <= REGION_RESET;
      search_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REGION: region_r <= cfg_wdata;
        CFG_SEARCH: search_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  tcw_front u_front (
    .in_bus      (in_bus),
    .search_mode (search_r),
    .clear_busy  (clear_busy),
    .q_full      (q_full),
    .push        (push),
    .push_item   (push_item)
  );

  tcw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .pop_item  (pop_item)
  );

  tcw_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .region_size (region_r),
    .q_valid     (q_not_empty),
    .q_item      (pop_item),
    .pop         (pop),
    .clear_busy  (clear_busy),
    .out_bus     (out_bus)
  );

endmodule
